@@ sv/pta_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the peer table with aging.
package pta_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ECNT_W = $clog2(MAX_RESULTS + 1);

   // bus widths
   localparam int REQ_W      = 256;
   localparam int RSP_W      = 152;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_APP_ID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_SELF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VER   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TTL       = 3'd6;

   // register reset values
   localparam logic [3:0]  MIN_VER_RST = 4'd1;
   localparam logic [3:0]  MAX_VER_RST = 4'd1;
   localparam logic [31:0] TTL_RST     = 32'd5000;

   // request actions
   localparam logic [1:0] ACT_PACKET = 2'd0;
   localparam logic [1:0] ACT_SWEEP  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // packet kinds
   localparam logic [1:0] KIND_HERE  = 2'd0;
   localparam logic [1:0] KIND_LEAVE = 2'd1;

   // result events
   localparam logic [3:0] EV_IGNORED       = 4'd0;
   localparam logic [3:0] EV_INSERTED      = 4'd1;
   localparam logic [3:0] EV_REFRESHED     = 4'd2;
   localparam logic [3:0] EV_REFRESHED_NEW = 4'd3;
   localparam logic [3:0] EV_REMOVED       = 4'd4;
   localparam logic [3:0] EV_LEAVE_UNKNOWN = 4'd5;
   localparam logic [3:0] EV_FULL_DROP     = 4'd6;
   localparam logic [3:0] EV_AGED          = 4'd7;
   localparam logic [3:0] EV_SWEEP_NONE    = 4'd8;
   localparam logic [3:0] EV_READ          = 4'd9;

   // request word, last field in the lowest bits
   typedef struct packed {
      logic [3:0]  pad;
      logic [3:0]  slot_index;
      logic [31:0] pkt_user_word;
      logic [63:0] pkt_snapshot;
      logic [31:0] pkt_peer_id;
      logic [31:0] pkt_app_id;
      logic [1:0]  pkt_kind;
      logic [3:0]  pkt_version;
      logic [15:0] src_port;
      logic [31:0] src_ip;
      logic [31:0] now_ms;
      logic [1:0]  action;
   } req_type;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic        slot_valid;
      logic [31:0] peer_user_word;
      logic [63:0] peer_snapshot;
      logic [15:0] peer_port;
      logic [31:0] peer_ip;
      logic [3:0]  event_res;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [63:0] snap;
      logic [31:0] uw;
      logic [31:0] seen;
   } entry_type;

   function automatic rsp_type make_rsp(logic [3:0] ev, logic [31:0] ip, logic [15:0] port,
                                        logic [63:0] snap, logic [31:0] uw, logic vld);
      rsp_type r;
      r.pad            = 3'd0;
      r.slot_valid     = vld;
      r.peer_user_word = uw;
      r.peer_snapshot  = snap;
      r.peer_port      = port;
      r.peer_ip        = ip;
      r.event_res      = ev;
      return r;
   endfunction

endpackage

@@ sv/peer_table_with_aging.sv @@
`timescale 1ns / 1ps
// Top level: peer table with aging, its sequencer, entry memory and result register.

// Keeps up to TABLE_DEPTH discovered peers. A request is a parsed announcement
// (action 0), an aging sweep (action 1) or a slot read (action 2). Packets that
// pass the version, application id and own-id checks are looked up by IP, or by
// IP and port, in a scan of the table that reads one slot per cycle, unless a
// sweep stalls, from the single read port of the entry memory and matches it in
// one shared compare unit; sweeps use the same scan with a 32-bit idle-time
// subtract and TTL compare. req_tready is low while a request is in work. A
// sweep gives one response per evicted peer (at most MAX_RESULTS), or a single
// sweep-none response if it evicts none, and stalls its scan while the response
// register is held by the downstream side. The final response of each request
// carries rsp_tlast. Valid bits are cleared by reset, so the table is usable the
// cycle after reset; the entry fields themselves are never reset. Registers are
// written through csr_we/csr_index/csr_wdata; the user must do so only while no
// request is in work, which the block itself does not enforce.
module peer_table_with_aging (
   input  logic                             clock,
   input  logic                             reset,
   // request: action, now_ms, src_ip, src_port, pkt_version, pkt_kind,
   // pkt_app_id, pkt_peer_id, pkt_snapshot, pkt_user_word, slot_index
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pta_pkg::REQ_W-1:0]        req_tdata,
   // response: event_res, peer_ip, peer_port, peer_snapshot, peer_user_word,
   // slot_valid
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pta_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tlast,
   // register writes
   input  logic                             csr_we,
   input  logic [pta_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pta_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DISP    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_RESOLVE = 3'd3;
   localparam logic [2:0] S_READOUT = 3'd4;
   localparam logic [2:0] S_FLUSH   = 3'd5;
   localparam logic [2:0] S_IGNORE  = 3'd6;

   // configuration registers
   logic [31:0] app_id_ff, own_id_ff, ttl_ff;
   logic        disc_self_ff, peer_mode_ff;
   logic [3:0]  min_ver_ff, max_ver_ff;

   // sequencer
   logic [2:0]                   state_ff, state_in;
   pta_pkg::req_type             req_ff, req_in;
   logic [pta_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [pta_pkg::CNT_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                         eval_vld_ff, eval_vld_in;
   logic [pta_pkg::IDX_W-1:0]    eval_idx_ff, eval_idx_in;
   logic                         found_ff, found_in;
   logic [pta_pkg::IDX_W-1:0]    found_idx_ff, found_idx_in;
   pta_pkg::entry_type           hit_ff, hit_in;
   logic                         free_vld_ff, free_vld_in;
   logic [pta_pkg::IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                         pend_vld_ff, pend_vld_in;
   pta_pkg::entry_type           pend_ff, pend_in;
   logic [pta_pkg::ECNT_W-1:0]   evict_cnt_ff, evict_cnt_in;

   // response register
   logic                         rsp_vld_ff, rsp_vld_in;
   pta_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         out_free, out_load;

   // entry memory
   pta_pkg::entry_type           mem [pta_pkg::TABLE_DEPTH];
   pta_pkg::entry_type           mem_rd_ff;
   logic                         mem_re, mem_we;
   logic [pta_pkg::IDX_W-1:0]    mem_raddr, mem_waddr;
   pta_pkg::entry_type           mem_wdata;

   // shared compare unit and scan helpers
   logic [31:0]                  idle_ms;
   logic                         ip_eq, port_eq, slot_v, stall, pkt_pass, newer;
   logic                         is_sweep;
   logic [7:0]                   slot_ext;
   logic                         slot_in_range;
   pta_pkg::entry_type           upd;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_id_ff    <= '0;
         own_id_ff    <= '0;
         disc_self_ff <= 1'b0;
         peer_mode_ff <= 1'b0;
         min_ver_ff   <= pta_pkg::MIN_VER_RST;
         max_ver_ff   <= pta_pkg::MAX_VER_RST;
         ttl_ff       <= pta_pkg::TTL_RST;
      end else if (csr_we) begin
         case (csr_index)
            pta_pkg::CSR_APP_ID:    app_id_ff    <= csr_wdata;
            pta_pkg::CSR_OWN_ID:    own_id_ff    <= csr_wdata;
            pta_pkg::CSR_DISC_SELF: disc_self_ff <= csr_wdata[0];
            pta_pkg::CSR_PEER_MODE: peer_mode_ff <= csr_wdata[0];
            pta_pkg::CSR_MIN_VER:   min_ver_ff   <= csr_wdata[3:0];
            pta_pkg::CSR_MAX_VER:   max_ver_ff   <= csr_wdata[3:0];
            pta_pkg::CSR_TTL:       ttl_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // packet admission check
   assign pkt_pass = (req_ff.pkt_version != 4'd0) && (req_ff.pkt_version >= min_ver_ff) &&
                     (req_ff.pkt_version <= max_ver_ff) && (req_ff.pkt_app_id == app_id_ff) &&
                     (disc_self_ff || (req_ff.pkt_peer_id != own_id_ff)) &&
                     !req_ff.pkt_kind[1];

   assign is_sweep = (req_ff.action == pta_pkg::ACT_SWEEP);
   assign ip_eq    = (mem_rd_ff.ip == req_ff.src_ip);
   assign port_eq  = (mem_rd_ff.port == req_ff.src_port);
   assign idle_ms  = req_ff.now_ms - mem_rd_ff.seen;
   assign slot_v   = valid_ff[eval_idx_ff];
   assign newer    = (hit_ff.snap < req_ff.pkt_snapshot);
   assign slot_ext = {4'd0, req_ff.slot_index};
   assign slot_in_range = (slot_ext < 8'(pta_pkg::TABLE_DEPTH));

   // a sweep holds its scan while a finished eviction cannot move on
   assign stall = (state_ff == S_SCAN) && is_sweep && eval_vld_ff && pend_vld_ff && !out_free;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      issue_cnt_in = issue_cnt_ff;
      eval_vld_in  = eval_vld_ff;
      eval_idx_in  = eval_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      hit_in       = hit_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      evict_cnt_in = evict_cnt_ff;
      out_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_waddr    = found_idx_ff;
      mem_wdata    = hit_ff;
      upd          = hit_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in   = pta_pkg::req_type'(req_tdata);
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            issue_cnt_in = '0;
            eval_vld_in  = 1'b0;
            found_in     = 1'b0;
            free_vld_in  = 1'b0;
            pend_vld_in  = 1'b0;
            evict_cnt_in = '0;
            case (req_ff.action)
               pta_pkg::ACT_PACKET: state_in = pkt_pass ? S_SCAN : S_IGNORE;
               pta_pkg::ACT_SWEEP:  state_in = S_SCAN;
               pta_pkg::ACT_READ: begin
                  mem_re    = 1'b1;
                  mem_raddr = slot_ext[pta_pkg::IDX_W-1:0];
                  state_in  = S_READOUT;
               end
               default: state_in = S_IGNORE;
            endcase
         end

         S_SCAN: begin
            if (!stall) begin
               // issue the next slot read
               if (issue_cnt_ff < pta_pkg::CNT_W'(pta_pkg::TABLE_DEPTH)) begin
                  mem_re       = 1'b1;
                  mem_raddr    = issue_cnt_ff[pta_pkg::IDX_W-1:0];
                  issue_cnt_in = issue_cnt_ff + 1'b1;
                  eval_vld_in  = 1'b1;
                  eval_idx_in  = issue_cnt_ff[pta_pkg::IDX_W-1:0];
               end else begin
                  eval_vld_in = 1'b0;
                  state_in    = is_sweep ? S_FLUSH : S_RESOLVE;
               end
               // evaluate the slot read last cycle
               if (eval_vld_ff) begin
                  if (is_sweep) begin
                     if (slot_v && (idle_ms > ttl_ff) &&
                         (evict_cnt_ff < pta_pkg::ECNT_W'(pta_pkg::MAX_RESULTS))) begin
                        valid_in[eval_idx_ff] = 1'b0;
                        evict_cnt_in = evict_cnt_ff + 1'b1;
                        pend_vld_in  = 1'b1;
                        pend_in      = mem_rd_ff;
                        if (pend_vld_ff) begin
                           out_load    = 1'b1;
                           rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_AGED, pend_ff.ip,
                                            pend_ff.port, pend_ff.snap, pend_ff.uw, 1'b0);
                           rsp_last_in = 1'b0;
                        end
                     end
                  end else begin
                     if (slot_v) begin
                        if (!found_ff && ip_eq && (!peer_mode_ff || port_eq)) begin
                           found_in     = 1'b1;
                           found_idx_in = eval_idx_ff;
                           hit_in       = mem_rd_ff;
                        end
                     end else if (!free_vld_ff) begin
                        free_vld_in = 1'b1;
                        free_idx_in = eval_idx_ff;
                     end
                  end
               end
            end
         end

         S_RESOLVE: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               if (req_ff.pkt_kind == pta_pkg::KIND_HERE) begin
                  if (found_ff) begin
                     upd.seen = req_ff.now_ms;
                     if (newer) begin
                        upd.snap = req_ff.pkt_snapshot;
                        upd.uw   = req_ff.pkt_user_word;
                     end
                     mem_we    = 1'b1;
                     mem_waddr = found_idx_ff;
                     mem_wdata = upd;
                     rsp_data_in = pta_pkg::make_rsp(
                        newer ? pta_pkg::EV_REFRESHED_NEW : pta_pkg::EV_REFRESHED,
                        upd.ip, upd.port, upd.snap, upd.uw, 1'b1);
                  end else if (free_vld_ff) begin
                     upd.ip    = req_ff.src_ip;
                     upd.port  = req_ff.src_port;
                     upd.snap  = req_ff.pkt_snapshot;
                     upd.uw    = req_ff.pkt_user_word;
                     upd.seen  = req_ff.now_ms;
                     mem_we    = 1'b1;
                     mem_waddr = free_idx_ff;
                     mem_wdata = upd;
                     valid_in[free_idx_ff] = 1'b1;
                     rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_INSERTED, upd.ip, upd.port,
                                                     upd.snap, upd.uw, 1'b1);
                  end else begin
                     rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_FULL_DROP, req_ff.src_ip,
                                      req_ff.src_port, req_ff.pkt_snapshot,
                                      req_ff.pkt_user_word, 1'b0);
                  end
               end else begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_REMOVED, hit_ff.ip,
                                      hit_ff.port, hit_ff.snap, hit_ff.uw, 1'b0);
                  end else begin
                     rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_LEAVE_UNKNOWN, '0, '0, '0,
                                                     '0, 1'b0);
                  end
               end
            end
         end

         S_READOUT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               if (slot_in_range && valid_ff[slot_ext[pta_pkg::IDX_W-1:0]]) begin
                  rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_READ, mem_rd_ff.ip,
                                   mem_rd_ff.port, mem_rd_ff.snap, mem_rd_ff.uw, 1'b1);
               end else begin
                  rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_READ, '0, '0, '0, '0, 1'b0);
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               if (pend_vld_ff) begin
                  rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_AGED, pend_ff.ip, pend_ff.port,
                                                  pend_ff.snap, pend_ff.uw, 1'b0);
               end else begin
                  rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_SWEEP_NONE, '0, '0, '0, '0,
                                                  1'b0);
               end
            end
         end

         S_IGNORE: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
               rsp_data_in = pta_pkg::make_rsp(pta_pkg::EV_IGNORED, '0, '0, '0, '0, 1'b0);
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // response valid: set on load, dropped when taken
   always_comb begin
      if (out_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         issue_cnt_ff <= '0;
         eval_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         free_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         evict_cnt_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_cnt_ff <= issue_cnt_in;
         eval_vld_ff  <= eval_vld_in;
         found_ff     <= found_in;
         free_vld_ff  <= free_vld_in;
         pend_vld_ff  <= pend_vld_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      eval_idx_ff  <= eval_idx_in;
      found_idx_ff <= found_idx_in;
      hit_ff       <= hit_in;
      free_idx_ff  <= free_idx_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   // never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response register overwritten");

   // a matched entry is still live when it is resolved
   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE && found_ff) |-> valid_ff[found_idx_ff])
      else $error("resolved hit on empty slot");

   // inserts only land in free slots
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE && out_load && !found_ff && free_vld_ff) |->
      !valid_ff[free_idx_ff])
      else $error("insert into occupied slot");

   // a sweep never reports more evictions than allowed
   a_evict_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (evict_cnt_ff <= pta_pkg::ECNT_W'(pta_pkg::MAX_RESULTS)))
      else $error("eviction count over limit");

endmodule
